[src/whm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Health monitor package
// Shared types and constants of the wake/verify health monitor.
// ----------------------------------------------------------------------------
package whm_pkg;

    localparam int MAX_RES = 64;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_ECHO  = 3'd1,
        CMD_WAKE1 = 3'd2,
        CMD_WAKEA = 3'd3,
        CMD_WRITE = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_IDLE     = 3'd0,
        ACT_WAKE     = 3'd1,
        ACT_PING     = 3'd2,
        ACT_GAVEUP   = 3'd3,
        ACT_MATCH    = 3'd4,
        ACT_VERIFIED = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        CFG_AUTOWAKE = 3'd0,
        CFG_PING_TO  = 3'd1,
        CFG_RETRY    = 3'd2,
        CFG_HEALTH   = 3'd3,
        CFG_PPA      = 3'd4,
        CFG_MAXATT   = 3'd5,
        CFG_IDENT    = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_E1,
        S_E2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic        up;
        logic        waking;
        logic [3:0]  attempt;
        logic [3:0]  verify;
        logic        po;
        logic [31:0] sent;
        logic [31:0] health;
        logic [15:0] oseq;
    } t_entry;

    typedef struct packed {
        logic        autowake;
        logic [31:0] ping_to;
        logic [31:0] retry;
        logic [31:0] health;
        logic [3:0]  ppa;
        logic [3:0]  maxatt;
        logic [15:0] ident;
    } t_cfg;

    typedef struct packed {
        t_entry      entry;
        t_action     a1;
        t_action     a2;
        logic [15:0] seq;
        logic        match;
    } t_eval;

    typedef struct packed {
        t_action     action;
        logic [4:0]  host_index;
        logic [31:0] target_ip;
        logic [15:0] icmp_seq;
        logic [3:0]  attempt;
    } t_result;

endpackage

[src/whm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Health monitor channels
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface whm_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] now_ms;
    logic [4:0]  entry_index;
    logic [31:0] new_ip;
    logic        new_valid;
    logic [31:0] source_ip;
    logic [7:0]  reply_type;
    logic [15:0] reply_ident;
    logic [15:0] reply_seq;

    modport source (output valid, cmd, now_ms, entry_index, new_ip, new_valid,
                    source_ip, reply_type, reply_ident, reply_seq, input ready);
    modport sink   (input valid, cmd, now_ms, entry_index, new_ip, new_valid,
                    source_ip, reply_type, reply_ident, reply_seq, output ready);
endinterface

interface whm_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [4:0]  host_index;
    logic [31:0] target_ip;
    logic [15:0] icmp_seq;
    logic [3:0]  attempt;
    logic        last;

    modport source (output valid, action, host_index, target_ip, icmp_seq, attempt,
                    last, input ready);
    modport sink   (input valid, action, host_index, target_ip, icmp_seq, attempt,
                    last, output ready);
endinterface

[src/whm_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Host table memory
// One-port-write, one-port-read table with registered read and per-entry
// written flags so unwritten entries read as all zero.
// ----------------------------------------------------------------------------
module whm_mem
    import whm_pkg::*;
#(
    parameter int HOSTS = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);
    t_entry             mem [HOSTS];
    logic [HOSTS-1:0]   r_init;
    t_entry             r_rdata;
    logic               r_rinit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (i_we) begin
            r_init[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
        r_rinit <= r_init[i_raddr];
    end

    assign o_rdata = r_rinit ? r_rdata : '0;
endmodule

[src/whm_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Host entry update
// Computes the new state of one entry and the actions it causes.
// ----------------------------------------------------------------------------
module whm_eval
    import whm_pkg::*;
(
    input  t_cmd        i_cmd,
    input  t_entry      i_entry,
    input  t_cfg        i_cfg,
    input  logic [31:0] i_now,
    input  logic [15:0] i_seq,
    input  logic [31:0] i_src,
    input  logic [15:0] i_rseq,
    output t_eval       o_eval
);
    logic [31:0] d_sent;
    logic [31:0] d_health;
    logic        mon;
    logic        was_up;

    assign d_sent   = i_now - i_entry.sent;
    assign d_health = i_now - i_entry.health;
    assign mon      = i_entry.valid && (i_entry.addr != 32'd0);

    always_comb begin
        o_eval       = '0;
        o_eval.entry = i_entry;
        o_eval.a1    = ACT_IDLE;
        o_eval.a2    = ACT_IDLE;
        o_eval.seq   = i_seq;
        was_up       = i_entry.up;
        case (i_cmd) inside
            CMD_TICK: begin
                if (mon) begin
                    if (i_entry.po && (d_sent >= i_cfg.ping_to)) begin
                        o_eval.entry.po = 1'b0;
                        o_eval.entry.up = 1'b0;
                        if (was_up && !i_entry.waking && i_cfg.autowake) begin
                            o_eval.entry.waking  = 1'b1;
                            o_eval.entry.attempt = 4'd1;
                            o_eval.entry.verify  = 4'd0;
                            o_eval.a1            = ACT_WAKE;
                            o_eval.a2            = ACT_PING;
                            o_eval.seq           = i_seq + 16'd1;
                            o_eval.entry.po      = 1'b1;
                            o_eval.entry.oseq    = i_seq + 16'd1;
                            o_eval.entry.sent    = i_now;
                        end
                    end
                    if (o_eval.entry.waking) begin
                        if (!o_eval.entry.po && (d_sent >= i_cfg.retry)) begin
                            if (o_eval.entry.verify != 4'hF) begin
                                o_eval.entry.verify = o_eval.entry.verify + 4'd1;
                            end
                            if (o_eval.entry.verify >= i_cfg.ppa) begin
                                if (o_eval.entry.attempt >= i_cfg.maxatt) begin
                                    o_eval.entry.waking  = 1'b0;
                                    o_eval.entry.attempt = 4'd0;
                                    o_eval.entry.verify  = 4'd0;
                                    o_eval.a1            = ACT_GAVEUP;
                                end else begin
                                    o_eval.entry.attempt = o_eval.entry.attempt + 4'd1;
                                    o_eval.entry.verify  = 4'd0;
                                    o_eval.a1            = ACT_WAKE;
                                    o_eval.a2            = ACT_PING;
                                    o_eval.seq           = i_seq + 16'd1;
                                    o_eval.entry.po      = 1'b1;
                                    o_eval.entry.oseq    = i_seq + 16'd1;
                                    o_eval.entry.sent    = i_now;
                                end
                            end else begin
                                o_eval.a1         = ACT_PING;
                                o_eval.seq        = i_seq + 16'd1;
                                o_eval.entry.po   = 1'b1;
                                o_eval.entry.oseq = i_seq + 16'd1;
                                o_eval.entry.sent = i_now;
                            end
                        end
                    end else if (d_health >= i_cfg.health) begin
                        o_eval.entry.health = i_now;
                        if (!o_eval.entry.po) begin
                            o_eval.a1         = ACT_PING;
                            o_eval.seq        = i_seq + 16'd1;
                            o_eval.entry.po   = 1'b1;
                            o_eval.entry.oseq = i_seq + 16'd1;
                            o_eval.entry.sent = i_now;
                        end
                    end
                end
            end
            CMD_ECHO: begin
                if (mon && (i_entry.addr == i_src) && i_entry.po &&
                    (i_entry.oseq == i_rseq)) begin
                    o_eval.match    = 1'b1;
                    o_eval.entry.po = 1'b0;
                    o_eval.entry.up = 1'b1;
                    if (i_entry.waking) begin
                        o_eval.entry.waking  = 1'b0;
                        o_eval.entry.attempt = 4'd0;
                        o_eval.entry.verify  = 4'd0;
                        o_eval.a1            = ACT_VERIFIED;
                    end else begin
                        o_eval.a1 = ACT_MATCH;
                    end
                end
            end
            CMD_WAKE1, CMD_WAKEA: begin
                if (i_entry.valid) begin
                    o_eval.a1 = ACT_WAKE;
                    if (i_entry.addr != 32'd0) begin
                        o_eval.entry.waking  = 1'b1;
                        o_eval.entry.attempt = 4'd1;
                        o_eval.entry.verify  = 4'd0;
                        o_eval.entry.up      = 1'b0;
                        o_eval.a2            = ACT_PING;
                        o_eval.seq           = i_seq + 16'd1;
                        o_eval.entry.po      = 1'b1;
                        o_eval.entry.oseq    = i_seq + 16'd1;
                        o_eval.entry.sent    = i_now;
                    end
                end
            end
            default: begin
            end
        endcase
    end
endmodule

[src/whm_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output stage
// Holds back one result so the final one of a command can carry last.
// ----------------------------------------------------------------------------
module whm_out
    import whm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_fin,
    output logic    o_can_push,
    output logic    o_can_fin,
    whm_res_if.source o_res
);
    logic    r_hv;
    t_result r_hold;
    logic    r_ov;
    t_result r_out;
    logic    r_last;
    logic    out_free;

    assign out_free   = !r_ov || o_res.ready;
    assign o_can_push = !r_hv || out_free;
    assign o_can_fin  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_push && o_can_push) begin
                r_hv <= 1'b1;
                if (r_hv) begin
                    r_ov <= 1'b1;
                end else if (o_res.ready) begin
                    r_ov <= 1'b0;
                end
            end else if (i_fin && out_free) begin
                r_hv <= 1'b0;
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_can_push) begin
            r_hold <= i_res;
            if (r_hv) begin
                r_out  <= r_hold;
                r_last <= 1'b0;
            end
        end else if (i_fin && out_free) begin
            r_out  <= r_hv ? r_hold : '0;
            r_last <= 1'b1;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.action     = r_out.action;
    assign o_res.host_index = r_out.host_index;
    assign o_res.target_ip  = r_out.target_ip;
    assign o_res.icmp_seq   = r_out.icmp_seq;
    assign o_res.attempt    = r_out.attempt;
    assign o_res.last       = r_last;
endmodule

[src/wake_verify_health_monitor_top.sv]
`timescale 1ns / 1ps
// Sequence: a command walks the host table, reading and updating each entry and
// sending each action it causes, then closes with a final result marked last.
// A write, or a command that does not start a walk, goes straight to the close.
// Throughput: one command at a time, set by the read-modify-write of the table.
// Reset: synchronous, active low; table reads as zero, config takes defaults.
// ----------------------------------------------------------------------------
// Wake/verify health monitor top level
// Sequencer over the host table that turns commands into action results.
// ----------------------------------------------------------------------------
module wake_verify_health_monitor_top
    import whm_pkg::*;
#(
    parameter int HOSTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    whm_cmd_if.sink     i_req,
    whm_res_if.source   o_rsp
);
    localparam int AW = (HOSTS > 1) ? $clog2(HOSTS) : 1;

    // Configuration registers; the user must write them only while the block is idle, as the block does not enforce it.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.autowake <= 1'b0;
            r_cfg.ping_to  <= 32'd3000;
            r_cfg.retry    <= 32'd10000;
            r_cfg.health   <= 32'd300000;
            r_cfg.ppa      <= 4'd6;
            r_cfg.maxatt   <= 4'd5;
            r_cfg.ident    <= 16'hBE01;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_AUTOWAKE: r_cfg.autowake <= i_cfg_data[0];
                CFG_PING_TO:  r_cfg.ping_to  <= i_cfg_data;
                CFG_RETRY:    r_cfg.retry    <= i_cfg_data;
                CFG_HEALTH:   r_cfg.health   <= i_cfg_data;
                CFG_PPA:      r_cfg.ppa      <= i_cfg_data[3:0];
                CFG_MAXATT:   r_cfg.maxatt   <= i_cfg_data[3:0];
                CFG_IDENT:    r_cfg.ident    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    t_state r_state;
    t_state n_state;

    // Latched command fields for the duration of the walk.
    t_cmd        r_cmd;
    logic [31:0] r_now;
    logic [31:0] r_src;
    logic [15:0] r_rseq;
    logic [AW-1:0] r_i;
    logic        r_single;
    logic [15:0] r_seq;
    logic [CNT_W-1:0] r_cnt;

    // Actions of the entry just updated, waiting to be sent.
    t_action     r_a1;
    t_action     r_a2;
    logic [31:0] r_ip;
    logic [3:0]  r_att;
    logic [15:0] r_pseq;
    logic        r_stop;

    logic        acc;
    logic        start_ok;
    logic        idx_ok;
    logic        is_last;
    t_entry      rdata;
    t_eval       ev;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry      mem_wdata;
    logic        push;
    logic        can_push;
    logic        can_fin;
    logic        fin;
    logic        room;
    t_result     res;
    t_action     cur_act;

    assign acc     = i_req.valid && i_req.ready;
    assign idx_ok  = {27'd0, i_req.entry_index} < HOSTS;
    assign is_last = r_single || (32'(r_i) == HOSTS - 1);
    assign room    = r_cnt < CNT_W'(MAX_RES);

    // A command walks the table unless it is answered at once.
    always_comb begin
        unique case (t_cmd'(i_req.cmd)) inside
            CMD_TICK, CMD_WAKEA: start_ok = 1'b1;
            CMD_ECHO:  start_ok = (i_req.reply_type == 8'd0) &&
                                  (i_req.reply_ident == r_cfg.ident);
            CMD_WAKE1: start_ok = idx_ok;
            default:   start_ok = 1'b0;
        endcase
    end

    whm_mem #(.HOSTS(HOSTS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_i),
        .o_rdata (rdata)
    );

    whm_eval u_eval (
        .i_cmd   (r_cmd),
        .i_entry (rdata),
        .i_cfg   (r_cfg),
        .i_now   (r_now),
        .i_seq   (r_seq),
        .i_src   (r_src),
        .i_rseq  (r_rseq),
        .o_eval  (ev)
    );

    // Table writes: an entry write straight from the command, or write-back.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = ev.entry;
        if (r_state == S_IDLE) begin
            mem_we          = acc && (t_cmd'(i_req.cmd) == CMD_WRITE) && idx_ok;
            mem_waddr       = AW'(i_req.entry_index);
            mem_wdata       = '0;
            mem_wdata.valid = i_req.new_valid;
            mem_wdata.addr  = i_req.new_ip;
        end else if (r_state == S_EV) begin
            mem_we = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = start_ok ? S_RD : S_DONE;
                end
            end
            S_RD: n_state = S_EV;
            S_EV: begin
                if (ev.a1 != ACT_IDLE) begin
                    n_state = S_E1;
                end else if (is_last || ev.match) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_E1: begin
                if (can_push || !room) begin
                    if (r_a2 != ACT_IDLE) begin
                        n_state = S_E2;
                    end else if (r_stop) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_E2: begin
                if (can_push || !room) begin
                    n_state = r_stop ? S_DONE : S_RD;
                end
            end
            S_DONE: begin
                if (can_fin) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        push        = 1'b0;
        fin         = 1'b0;
        cur_act     = r_a1;
        unique case (r_state)
            S_E1: push = room;
            S_E2: begin
                push    = room;
                cur_act = r_a2;
            end
            S_DONE: fin = 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        res            = '0;
        res.action     = cur_act;
        res.host_index = 5'(r_i);
        res.target_ip  = r_ip;
        res.attempt    = r_att;
        res.icmp_seq   = (cur_act == ACT_PING) ? r_pseq : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seq   <= 16'd0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EV) begin
                r_seq <= ev.seq;
            end
            if (r_state == S_IDLE) begin
                r_cnt <= '0;
            end else if (push && can_push) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cmd    <= t_cmd'(i_req.cmd);
            r_now    <= i_req.now_ms;
            r_src    <= i_req.source_ip;
            r_rseq   <= i_req.reply_seq;
            r_single <= (t_cmd'(i_req.cmd) == CMD_WAKE1);
            r_i      <= (t_cmd'(i_req.cmd) == CMD_WAKE1) ? AW'(i_req.entry_index) : '0;
        end else if (((r_state == S_EV) && (n_state == S_RD)) ||
                     ((r_state != S_EV) && (r_state != S_IDLE) && (n_state == S_RD))) begin
            r_i <= r_i + AW'(1);
        end
        if (r_state == S_EV) begin
            r_a1   <= ev.a1;
            r_a2   <= ev.a2;
            r_ip   <= rdata.addr;
            r_att  <= ev.entry.attempt;
            r_pseq <= ev.seq;
            r_stop <= is_last || ev.match;
        end
    end

    whm_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_res      (res),
        .i_fin      (fin),
        .o_can_push (can_push),
        .o_can_fin  (can_fin),
        .o_res      (o_rsp)
    );
endmodule
